>>> design/upt_pkg.sv
// Package for the UTF-8 prefix truncator: field widths, byte-class constants,
// the lead-byte size decode and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package upt_pkg;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 16;
  localparam int OUT_LEN_W = 16;
  localparam int SEQ_W     = 3;

  // Limit after reset
  localparam logic [CFG_W-1:0] MAX_BYTES_RST = 16'd255;

  // Continuation byte pattern 10xxxxxx
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

  // Lead byte ranges
  localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;

  // Leads with a restricted second byte, and the bounds used
  localparam logic [BYTE_W-1:0] LEAD_E0   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_ED   = 8'hED;
  localparam logic [BYTE_W-1:0] LEAD_F0   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_F4   = 8'hF4;
  localparam logic [BYTE_W-1:0] SECOND_A0 = 8'hA0;
  localparam logic [BYTE_W-1:0] SECOND_90 = 8'h90;

  // Sequence lengths
  localparam logic [SEQ_W-1:0] SEQ_NONE = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_ONE  = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_TWO  = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_THR  = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_FOUR = 3'd4;

  // Code point length given by a lead byte, SEQ_NONE for a bad lead
  function automatic logic [SEQ_W-1:0] lead_size(input logic [BYTE_W-1:0] b);
    logic [SEQ_W-1:0] n;
    n = SEQ_NONE;
    if (b < CONT_TAG) begin
      n = SEQ_ONE;
    end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
      n = SEQ_TWO;
    end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
      n = SEQ_THR;
    end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
      n = SEQ_FOUR;
    end
    return n;
  endfunction

  // One result word
  typedef struct packed {
    logic [OUT_LEN_W-1:0] valid_length;
    logic                 stopped;
    logic                 text_done;
  } result_t;

endpackage

>>> design/upt_if.sv
// Channel interfaces of the UTF-8 prefix truncator: text bytes in, result
// words out, and the limit register write channel.
// Depends on upt_pkg.
`timescale 1ns / 1ps

// Text byte channel
interface upt_in_if
  import upt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// Result word channel
interface upt_out_if
  import upt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUT_LEN_W-1:0] valid_length;
  logic                 stopped;
  logic                 text_done;

  modport source (output valid, output valid_length, output stopped, output text_done,
                  input ready);
  modport sink   (input valid, input valid_length, input stopped, input text_done,
                  output ready);
endinterface

// Limit register write channel
interface upt_cfg_if
  import upt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_bytes;

  modport source (output valid, output max_bytes, input ready);
  modport sink   (input valid, input max_bytes, output ready);
endinterface

>>> design/upt_obuf.sv
// Two-entry output buffer of the UTF-8 prefix truncator: a result register
// plus a skid register, so the input side can take a word while one waits.
// Depends on upt_pkg and upt_out_if.
`timescale 1ns / 1ps

module upt_obuf
  import upt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  result_t          push_data,
  output logic             full,
  upt_out_if.source        result
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && result.ready;
  assign full = skid_valid;

  // Control: head and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (out_valid && !pop) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Payload: new word to head, or to skid while head is stalled
  always_ff @(posedge clk) begin
    if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign result.valid        = out_valid;
  assign result.valid_length = out_data.valid_length;
  assign result.stopped      = out_data.stopped;
  assign result.text_done    = out_data.text_done;

`ifndef SYNTHESIS
  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty head");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("word pushed into full buffer");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !result.ready) |=> skid_valid)
    else $error("stalled push did not land in skid");
`endif

endmodule

>>> design/utf8_prefix_truncator.sv
// UTF-8 prefix truncator. Takes one text byte per cycle (back to back) and
// returns one word per byte: the length, in bytes, of the longest prefix of
// whole, valid code points that fits within the max_bytes limit, a stopped flag
// once the scan has hit a problem, and text_done on the last byte, where the
// length is final. The decision for a byte is made in the cycle it is
// accepted, against the scan state register, and its word is registered into
// the output head, or into the skid entry while the head waits. A two-entry
// output buffer keeps input accepting while one word waits; input ready drops
// only when both entries are full. The limit register is written at any time
// through cfg and takes effect from the next byte. LENGTH_BITS sets the width
// of the length counter (limit is capped at 2^LENGTH_BITS - 1).
// Depends on upt_pkg, upt_if and upt_obuf.
`timescale 1ns / 1ps

module utf8_prefix_truncator
  import upt_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  upt_cfg_if.sink    cfg,
  upt_in_if.sink     text,
  upt_out_if.source  result
);

  // Compare width covers both the counter and the limit register
  localparam int CW = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] LEN_CAP = CW'({LENGTH_BITS{1'b1}});

  // Limit register
  logic [CFG_W-1:0] max_bytes;

  // Scan state
  logic [LENGTH_BITS-1:0] committed_length, committed_length_next;
  logic [BYTE_W-1:0]      lead_value, lead_value_next;
  logic [SEQ_W-1:0]       seq_len, seq_len_next;
  logic [SEQ_W-1:0]       seq_seen, seq_seen_next;
  logic                   seq_ok, seq_ok_next;
  logic                   halted, halted_next;

  logic             accept;
  logic             buf_full;
  result_t          step_result;
  logic [CW-1:0]    limit;
  logic [CW-1:0]    commit_ext;
  logic [SW-1:0]    lead_sum;
  logic [SEQ_W-1:0] lead_n;
  logic [SEQ_W-1:0] seen_inc;
  logic             follow_good;
  logic             ok_acc;

  assign cfg.ready  = 1'b1;
  assign text.ready = !buf_full;
  assign accept     = text.valid && text.ready;

  // Limit register write
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RST;
    end else if (cfg.valid) begin
      max_bytes <= cfg.max_bytes;
    end
  end

  // Effective limit and lead-byte arithmetic
  assign limit      = (CW'(max_bytes) < LEN_CAP) ? CW'(max_bytes) : LEN_CAP;
  assign commit_ext = CW'(committed_length);
  assign lead_n     = lead_size(text.text_byte);
  assign lead_sum   = SW'(commit_ext) + SW'(lead_n);
  assign seen_inc   = seq_seen + SEQ_ONE;

  // Continuation byte checks, second-byte ranges after special leads
  always_comb begin
    follow_good = (text.text_byte & CONT_MASK) == CONT_TAG;
    if (seq_seen == SEQ_ONE) begin
      if (lead_value == LEAD_E0 && text.text_byte <  SECOND_A0) follow_good = 1'b0;
      if (lead_value == LEAD_ED && text.text_byte >= SECOND_A0) follow_good = 1'b0;
      if (lead_value == LEAD_F0 && text.text_byte <  SECOND_90) follow_good = 1'b0;
      if (lead_value == LEAD_F4 && text.text_byte >= SECOND_90) follow_good = 1'b0;
    end
    ok_acc = seq_ok && follow_good;
  end

  // Per-byte scan step
  always_comb begin
    committed_length_next = committed_length;
    lead_value_next       = lead_value;
    seq_len_next          = seq_len;
    seq_seen_next         = seq_seen;
    seq_ok_next           = seq_ok;
    halted_next           = halted;

    if (!halted) begin
      if (seq_len == SEQ_NONE) begin
        // Lead byte
        if (commit_ext >= limit) begin
          halted_next = 1'b1;
        end else if (lead_n == SEQ_NONE || text.text_byte == '0 ||
                     lead_sum > SW'(limit)) begin
          halted_next = 1'b1;
        end else if (lead_n == SEQ_ONE) begin
          committed_length_next = committed_length + LENGTH_BITS'(1);
        end else begin
          lead_value_next = text.text_byte;
          seq_len_next    = lead_n;
          seq_seen_next   = SEQ_ONE;
          seq_ok_next     = 1'b1;
        end
      end else begin
        // Continuation byte
        if (seen_inc >= seq_len) begin
          if (ok_acc) begin
            committed_length_next = committed_length + LENGTH_BITS'(seq_len);
          end else begin
            halted_next = 1'b1;
          end
          lead_value_next = '0;
          seq_len_next    = SEQ_NONE;
          seq_seen_next   = SEQ_NONE;
          seq_ok_next     = 1'b1;
        end else begin
          seq_seen_next = seen_inc;
          seq_ok_next   = ok_acc;
        end
      end
    end

    // Text ends inside a code point
    if (text.last_byte && !halted_next && seq_len_next != SEQ_NONE) begin
      halted_next = 1'b1;
    end

    step_result.valid_length = OUT_LEN_W'(committed_length_next);
    step_result.stopped      = halted_next;
    step_result.text_done    = text.last_byte;
  end

  // Scan state register, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      committed_length <= '0;
      lead_value       <= '0;
      seq_len          <= SEQ_NONE;
      seq_seen         <= SEQ_NONE;
      seq_ok           <= 1'b1;
      halted           <= 1'b0;
    end else if (accept) begin
      if (text.last_byte) begin
        committed_length <= '0;
        lead_value       <= '0;
        seq_len          <= SEQ_NONE;
        seq_seen         <= SEQ_NONE;
        seq_ok           <= 1'b1;
        halted           <= 1'b0;
      end else begin
        committed_length <= committed_length_next;
        lead_value       <= lead_value_next;
        seq_len          <= seq_len_next;
        seq_seen         <= seq_seen_next;
        seq_ok           <= seq_ok_next;
        halted           <= halted_next;
      end
    end
  end

  // Result buffer
  upt_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .full      (buf_full),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_open_seq_counts: assert property (@(posedge clk) disable iff (rst)
    (seq_len != SEQ_NONE) |-> (seq_seen != SEQ_NONE && seq_seen < seq_len))
    else $error("open sequence with bad byte count");

  a_closed_seq_clean: assert property (@(posedge clk) disable iff (rst)
    (seq_len == SEQ_NONE) |-> (seq_seen == SEQ_NONE && seq_ok && lead_value == '0))
    else $error("sequence fields not cleared");

  a_open_seq_len: assert property (@(posedge clk) disable iff (rst)
    (seq_len == SEQ_NONE || seq_len == SEQ_TWO || seq_len == SEQ_THR ||
     seq_len == SEQ_FOUR))
    else $error("impossible sequence length");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && text.last_byte) |=>
      (committed_length == '0 && !halted && seq_len == SEQ_NONE))
    else $error("scan state not cleared after last byte");
`endif

endmodule

>>> tb/tb_utf8_prefix_truncator.sv
// Testbench for utf8_prefix_truncator. It streams texts of whole, broken and noisy
// UTF-8 code points under several byte limits and scores each result word.
// Depends on upt_pkg, upt_if and the truncator RTL.
`timescale 1ns / 1ps

module tb_utf8_prefix_truncator;
  import upt_pkg::*;

  localparam int LENGTH_BITS = 16;
  localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] CONT_TOP = 8'hBF;
  localparam logic [BYTE_W-1:0] BYTE_TOP = 8'hFF;

  // Tracks the expected prefix length for every accepted text byte
  class utf8_length_scoreboard;
    logic [CFG_W-1:0]       limit;
    logic [LENGTH_BITS-1:0] committed;
    logic [BYTE_W-1:0]      lead;
    logic [SEQ_W-1:0]       seq_len;
    logic [SEQ_W-1:0]       seq_seen;
    bit                     seq_ok;
    bit                     halted;
    result_t                expected_words[$];
    int                     errors;

    function new();
      limit  = MAX_BYTES_RST;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      committed = '0;
      lead      = '0;
      seq_len   = SEQ_NONE;
      seq_seen  = SEQ_NONE;
      seq_ok    = 1'b1;
      halted    = 1'b0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] value);
      limit = value;
    endfunction

    // Bytes in the code point that a lead byte opens; SEQ_NONE if it is no lead
    function logic [SEQ_W-1:0] code_point_size(logic [BYTE_W-1:0] b);
      if (b < CONT_TAG) return SEQ_ONE;
      if (b >= LEAD2_LO && b <= LEAD2_HI) return SEQ_TWO;
      if (b >= LEAD3_LO && b <= LEAD3_HI) return SEQ_THR;
      if (b >= LEAD4_LO && b <= LEAD4_HI) return SEQ_FOUR;
      return SEQ_NONE;
    endfunction

    function void take_lead(logic [BYTE_W-1:0] b);
      logic [SEQ_W-1:0] n;
      longint           cap;
      longint           top;
      top = (64'd1 << LENGTH_BITS) - 1;
      cap = (longint'(limit) < top) ? longint'(limit) : top;
      n   = code_point_size(b);
      if (longint'(committed) >= cap || n == SEQ_NONE || b == NUL_BYTE ||
          longint'(committed) + longint'(n) > cap) begin
        halted = 1'b1;
      end else if (n == SEQ_ONE) begin
        committed = committed + 1'b1;
      end else begin
        lead     = b;
        seq_len  = n;
        seq_seen = SEQ_ONE;
        seq_ok   = 1'b1;
      end
    endfunction

    function void take_follow(logic [BYTE_W-1:0] b);
      bit good;
      good = (b & CONT_MASK) == CONT_TAG;
      // second byte bounds against overlong forms and surrogates
      if (seq_seen == SEQ_ONE) begin
        if (lead == LEAD_E0 && b < SECOND_A0) good = 1'b0;
        if (lead == LEAD_ED && b >= SECOND_A0) good = 1'b0;
        if (lead == LEAD_F0 && b < SECOND_90) good = 1'b0;
        if (lead == LEAD_F4 && b >= SECOND_90) good = 1'b0;
      end
      if (!good) seq_ok = 1'b0;
      seq_seen = seq_seen + 1'b1;
      if (seq_seen >= seq_len) begin
        if (seq_ok) committed = committed + seq_len;
        else halted = 1'b1;
        seq_len  = SEQ_NONE;
        seq_seen = SEQ_NONE;
        seq_ok   = 1'b1;
        lead     = '0;
      end
    endfunction

    // Accepted text byte: work out its result word and queue it
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      result_t w;
      if (!halted) begin
        if (seq_len == SEQ_NONE) take_lead(b);
        else take_follow(b);
      end
      // partial code point cut off by the end of the text
      if (last && !halted && seq_len != SEQ_NONE) halted = 1'b1;
      w.valid_length = committed[OUT_LEN_W-1:0];
      w.stopped      = halted;
      w.text_done    = last;
      expected_words.push_back(w);
      if (last) clear_text();
    endfunction

    // Accepted result word against the oldest expectation
    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual length %0d stopped %0b done %0b",
                 $time, got.valid_length, got.stopped, got.text_done);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.valid_length !== want.valid_length) begin
        $display("%0t: valid_length mismatch: expected %0d, actual %0d",
                 $time, want.valid_length, got.valid_length);
        errors++;
      end
      if (got.stopped !== want.stopped) begin
        $display("%0t: stopped mismatch: expected %0b, actual %0b",
                 $time, want.stopped, got.stopped);
        errors++;
      end
      if (got.text_done !== want.text_done) begin
        $display("%0t: text_done mismatch: expected %0b, actual %0b",
                 $time, want.text_done, got.text_done);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  upt_cfg_if cfg_ch();
  upt_in_if  text_ch();
  upt_out_if result_ch();

  utf8_prefix_truncator #(
    .LENGTH_BITS(LENGTH_BITS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .text   (text_ch),
    .result (result_ch)
  );

  utf8_length_scoreboard sb;
  int src_idle_pct  = 13;
  int sink_idle_pct = 80;
  int hold_request  = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb_utf8_prefix_truncator failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_limit(cfg_ch.max_bytes);
      if (text_ch.valid && text_ch.ready) sb.note_byte(text_ch.text_byte, text_ch.last_byte);
      if (result_ch.valid && result_ch.ready) begin
        sb.check_word('{valid_length: result_ch.valid_length,
                        stopped:      result_ch.stopped,
                        text_done:    result_ch.text_done});
      end
    end
  end

  // One text byte, with random gaps before it; entered and left at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.last_byte <= last;
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_text(input logic [BYTE_W-1:0] t[$]);
    for (int i = 0; i < t.size(); i++) begin
      send_byte(t[i], i == t.size() - 1);
    end
  endtask

  // Let every outstanding word come back before touching the limit
  task automatic drain_words();
    text_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.max_bytes <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] any_follow();
    return BYTE_W'($urandom_range(CONT_TAG, CONT_TOP));
  endfunction

  // Mostly well-formed code points with random content; some noise and breaks
  function automatic void build_text(output logic [BYTE_W-1:0] t[$]);
    int               kind;
    int               pos;
    logic [BYTE_W-1:0] lead_b;
    t = {};
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        t.push_back(BYTE_W'($urandom_range(1, CONT_TAG - 1)));
      end else if (kind < 37) begin
        t.push_back(NUL_BYTE);
      end else if (kind < 55) begin
        t.push_back(BYTE_W'($urandom_range(LEAD2_LO, LEAD2_HI)));
        t.push_back(any_follow());
      end else if (kind < 75) begin
        lead_b = BYTE_W'($urandom_range(LEAD3_LO, LEAD3_HI));
        t.push_back(lead_b);
        if (lead_b == LEAD_E0) t.push_back(BYTE_W'($urandom_range(SECOND_A0, CONT_TOP)));
        else if (lead_b == LEAD_ED) t.push_back(BYTE_W'($urandom_range(CONT_TAG, SECOND_A0 - 1)));
        else t.push_back(any_follow());
        t.push_back(any_follow());
      end else if (kind < 90) begin
        lead_b = BYTE_W'($urandom_range(LEAD4_LO, LEAD4_HI));
        t.push_back(lead_b);
        if (lead_b == LEAD_F0) t.push_back(BYTE_W'($urandom_range(SECOND_90, CONT_TOP)));
        else if (lead_b == LEAD_F4) t.push_back(BYTE_W'($urandom_range(CONT_TAG, SECOND_90 - 1)));
        else t.push_back(any_follow());
        t.push_back(any_follow());
        t.push_back(any_follow());
      end else begin
        t.push_back(BYTE_W'($urandom_range(0, BYTE_TOP)));
      end
    end
    // break some texts: cut the tail off, or spoil one byte
    kind = $urandom_range(99);
    if (kind < 8 && t.size() > 1) begin
      void'(t.pop_back());
    end else if (kind < 18) begin
      pos = $urandom_range(0, t.size() - 1);
      if ($urandom_range(1)) t[pos] = BYTE_W'($urandom_range(0, BYTE_TOP));
      else t[pos] = any_follow();
    end
  endfunction

  // Stimulus
  initial begin
    logic [BYTE_W-1:0] msg[$];
    logic [CFG_W-1:0]  seg_limit[6];
    int                sent;

    sb  = new();
    rst = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.max_bytes  = '0;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    text_ch.last_byte = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed texts under the reset limit
    msg = '{8'h41};                                   send_text(msg); // single ASCII byte
    msg = '{8'h7F, 8'h00, 8'h41};                     send_text(msg); // NUL lead, then ignored
    msg = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_text(msg); // two and four byte
    msg = '{8'hE0, 8'h9F};                            send_text(msg); // overlong after E0
    msg = '{8'hED, 8'hA0};                            send_text(msg); // surrogate
    msg = '{8'hF0, 8'h8F};                            send_text(msg); // overlong after F0
    msg = '{8'hF4, 8'h90};                            send_text(msg); // above U+10FFFF
    msg = '{8'hC2, 8'h41};                            send_text(msg); // bad continuation
    msg = '{8'h80};                                   send_text(msg); // stray continuation
    msg = '{8'hFF};                                   send_text(msg); // invalid lead
    msg = '{8'hE1, 8'h80};                            send_text(msg); // cut off by the end
    drain_words();

    // Limit of zero stops on the first lead
    write_limit('0);
    msg = '{8'h41};
    send_text(msg);
    drain_words();

    // Three byte code point would cross a limit of five
    write_limit(16'd5);
    msg = '{8'h61, 8'h62, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC};
    send_text(msg);
    drain_words();

    // Random segments: two per idling pattern, each under its own limit
    seg_limit = '{16'hFFFF, 16'd0, 16'd1, 16'd7, CFG_W'($urandom_range(2, 20)), 16'd3};
    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        src_idle_pct  = 13;
        sink_idle_pct = 80;
      end else if (seg < 4) begin
        src_idle_pct  = 80;
        sink_idle_pct = 13;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_limit(seg_limit[seg]);
      // long receiver hold-off so the output buffer fills and input stalls
      if (seg == 4) hold_request = 60;
      sent = 0;
      while (sent < 125) begin
        build_text(msg);
        send_text(msg);
        sent += msg.size();
      end
      drain_words();
    end

    repeat (5) @(negedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("tb_utf8_prefix_truncator passed");
    end else begin
      $display("tb_utf8_prefix_truncator failed");
    end
    $finish;
  end

endmodule
